FILE: src/fermat_probable_prime_round_defines.svh
// assertion macros for the fermat probable prime round block
// used by the top level; expects signals named clock and reset in scope
`ifndef FERMAT_PROBABLE_PRIME_ROUND_DEFINES_SVH
`define FERMAT_PROBABLE_PRIME_ROUND_DEFINES_SVH

// same-cycle implication
`define FPPR_ASSERT_IMP(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication
`define FPPR_ASSERT_NXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: src/fppr_pkg.sv
// shared types for the fermat probable prime round block
// no dependencies
`default_nettype none

package fppr_pkg;

   typedef struct packed {
      logic start;
   } fppr_mm_ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } fppr_mm_status_type;

endpackage

`default_nettype wire

FILE: src/fppr_modmul.sv
// iterative modular multiplier, one multiplier bit per cycle, msb first
// computes (a * b) mod m for a < m; b may be any value; depends on fppr_pkg
`default_nettype none

module fppr_modmul #(
   parameter int N = 32
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire fppr_pkg::fppr_mm_ctrl_type  ctrl,
   input  wire logic [N-1:0]                op_a,
   input  wire logic [N-1:0]                op_b,
   input  wire logic [N-1:0]                modulus,
   output fppr_pkg::fppr_mm_status_type     status,
   output logic [N-1:0]                     result
);
   import fppr_pkg::*;

   localparam int W  = N + 3;
   localparam int CW = $clog2(N);

   logic [N-1:0]  r_ff, r_in;
   logic [N-1:0]  a_ff, a_in;
   logic [N-1:0]  b_ff, b_in;
   logic [N-1:0]  m_ff, m_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;

   logic [W-1:0]  sum;
   logic [W-1:0]  diff1;
   logic [W-1:0]  diff2;
   logic [N-1:0]  step_r;

   // r = 2r + bit*a, then bring back below m (sum stays below 3m)
   always_comb begin
      sum    = {2'b00, r_ff, 1'b0} + (b_ff[N-1] ? {3'b000, a_ff} : {W{1'b0}});
      diff1  = sum - {3'b000, m_ff};
      diff2  = sum - {2'b00, m_ff, 1'b0};
      if (!diff2[W-1]) begin
         step_r = diff2[N-1:0];
      end else if (!diff1[W-1]) begin
         step_r = diff1[N-1:0];
      end else begin
         step_r = sum[N-1:0];
      end
   end

   always_comb begin
      r_in    = r_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         r_in   = step_r;
         b_in   = {b_ff[N-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (ctrl.start) begin
         r_in    = '0;
         a_in    = op_a;
         b_in    = op_b;
         m_in    = modulus;
         cnt_in  = '0;
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign result      = r_ff;

endmodule

`default_nettype wire

FILE: src/fermat_probable_prime_round.sv
// One Fermat round per item: the item carries a candidate and a witness, and
// the single result says whether witness^(candidate-1) mod candidate is 1.
// Candidates below 2 and even candidates other than 2 fail at once, going
// straight to the finish state. Otherwise one shared bit-serial modular
// multiplier does all the work: one product reduces the witness, then every
// exponent bit takes one squaring and each set bit one more multiply. Only
// the low OPERAND_BITS bits of candidate and witness are used. req_stall
// stays high while an item is at work; a new item is taken while the
// previous result still waits on rsp_stall.
`default_nettype none
`include "fermat_probable_prime_round_defines.svh"

module fermat_probable_prime_round #(
   parameter int OPERAND_BITS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_candidate,
   input  wire logic [31:0] req_witness,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_passes
);
   import fppr_pkg::*;

   localparam int N = OPERAND_BITS;

   localparam logic [2:0] ST_IDLE      = 3'd0;
   localparam logic [2:0] ST_RED_ISSUE = 3'd1;
   localparam logic [2:0] ST_RED_WAIT  = 3'd2;
   localparam logic [2:0] ST_BIT       = 3'd3;
   localparam logic [2:0] ST_MUL_WAIT  = 3'd4;
   localparam logic [2:0] ST_SQR_ISSUE = 3'd5;
   localparam logic [2:0] ST_SQR_WAIT  = 3'd6;
   localparam logic [2:0] ST_FIN       = 3'd7;

   localparam logic [N-1:0] ONE = {{(N-1){1'b0}}, 1'b1};

   logic [2:0]   state_ff, state_in;
   logic [N-1:0] mod_ff, mod_in;
   logic [N-1:0] wit_ff, wit_in;
   logic [N-1:0] exp_ff, exp_in;
   logic [N-1:0] acc_ff, acc_in;
   logic [N-1:0] sq_ff, sq_in;
   logic         ok_ff, ok_in;
   logic         rsp_valid_ff, rsp_valid_in;
   logic         rsp_passes_ff, rsp_passes_in;

   logic [N-1:0] cand;
   logic         cand_ok;
   logic         req_take;
   logic         mm_wait;

   fppr_mm_ctrl_type   mm_ctrl;
   fppr_mm_status_type mm_stat;
   logic [N-1:0]       mm_a;
   logic [N-1:0]       mm_b;
   logic [N-1:0]       mm_res;

   assign cand     = req_candidate[N-1:0];
   assign cand_ok  = (cand > ONE) && ((cand == {ONE[N-2:0], 1'b0}) || cand[0]);
   assign req_take = req_valid && !req_stall;

   fppr_modmul #(
      .N(N)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (mm_ctrl),
      .op_a    (mm_a),
      .op_b    (mm_b),
      .modulus (mod_ff),
      .status  (mm_stat),
      .result  (mm_res)
   );

   // operand select for the shared multiplier
   always_comb begin
      mm_ctrl.start = 1'b0;
      mm_a          = sq_ff;
      mm_b          = sq_ff;
      case (state_ff)
         ST_RED_ISSUE: begin
            mm_ctrl.start = 1'b1;
            mm_a          = ONE;
            mm_b          = wit_ff;
         end
         ST_BIT: begin
            mm_ctrl.start = (exp_ff != '0);
            if (exp_ff[0]) begin
               mm_a = acc_ff;
            end
         end
         ST_SQR_ISSUE: begin
            mm_ctrl.start = 1'b1;
         end
         default: begin
            mm_ctrl.start = 1'b0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      mod_in        = mod_ff;
      wit_in        = wit_ff;
      exp_in        = exp_ff;
      acc_in        = acc_ff;
      sq_in         = sq_ff;
      ok_in         = ok_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_passes_in = rsp_passes_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               mod_in   = cand;
               wit_in   = req_witness[N-1:0];
               exp_in   = cand - ONE;
               acc_in   = ONE;
               ok_in    = cand_ok;
               state_in = cand_ok ? ST_RED_ISSUE : ST_FIN;
            end
         end
         ST_RED_ISSUE: begin
            state_in = ST_RED_WAIT;
         end
         ST_RED_WAIT: begin
            if (mm_stat.done) begin
               sq_in    = mm_res;
               state_in = ST_BIT;
            end
         end
         ST_BIT: begin
            if (exp_ff == '0) begin
               state_in = ST_FIN;
            end else if (exp_ff[0]) begin
               state_in = ST_MUL_WAIT;
            end else begin
               state_in = ST_SQR_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mm_stat.done) begin
               acc_in   = mm_res;
               state_in = ST_SQR_ISSUE;
            end
         end
         ST_SQR_ISSUE: begin
            state_in = ST_SQR_WAIT;
         end
         ST_SQR_WAIT: begin
            if (mm_stat.done) begin
               sq_in    = mm_res;
               exp_in   = {1'b0, exp_ff[N-1:1]};
               state_in = ST_BIT;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_passes_in = ok_ff && (acc_ff == ONE);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mod_ff        <= mod_in;
      wit_ff        <= wit_in;
      exp_ff        <= exp_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      ok_ff         <= ok_in;
      rsp_passes_ff <= rsp_passes_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_passes = rsp_passes_ff;

   // states that wait on the multiplier
   assign mm_wait = (state_ff == ST_RED_WAIT) || (state_ff == ST_MUL_WAIT) ||
                    (state_ff == ST_SQR_WAIT);

   `FPPR_ASSERT_NXT(a_take_goes_busy, req_take, req_stall, "accepted item did not start work")
   `FPPR_ASSERT_IMP(a_start_when_free, mm_ctrl.start, !mm_stat.busy, "start while busy")
   `FPPR_ASSERT_IMP(a_rsp_from_fin, $rose(rsp_valid), $past(state_ff) == ST_FIN, "stray result")
   `FPPR_ASSERT_IMP(a_done_in_wait, mm_stat.done, mm_wait, "product done with no waiter")

endmodule

`default_nettype wire
